>>> design/mahs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio header scanner package
// Shared item types, controller commands, divider sizes and decode tables.
// ----------------------------------------------------------------------------
package mahs_pkg;

  localparam int DIV_W  = 43;
  localparam int DSR_W  = 16;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam logic [1:0] SEL_FS  = 2'd0;
  localparam logic [1:0] SEL_FC  = 2'd1;
  localparam logic [1:0] SEL_DUR = 2'd2;

  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  localparam logic [1:0] MODE_MONO = 2'd3;

  localparam logic [17:0] K_MPEG1 = 18'd144000;
  localparam logic [17:0] K_MPEG2 = 18'd72000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       last;
  } mahs_in_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  version;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding;
    logic [1:0]  chan_mode;
    logic [10:0] frm_len;
    logic [10:0] frm_samples;
    logic [31:0] hdr_pos;
    logic [31:0] frame_count;
    logic [31:0] duration_seconds;
    logic [5:0]  side_info_length;
  } mahs_out_t;

  typedef struct packed {
    logic       shift;
    logic       load_miss;
    logic       load_hit;
    logic       div_go;
    logic [1:0] div_sel;
    logic       cap_div;
    logic       cap_mul;
  } mahs_cmd_t;

  typedef struct packed {
    logic hit;
    logic div_done;
    logic out_valid;
  } mahs_sts_t;

  function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [3:0] idx);
    logic [8:0] v;
    v = '0;
    if (ver == VER_MPEG1) begin
      case (idx)
        4'd1: v = 9'd32;   4'd2: v = 9'd40;   4'd3: v = 9'd48;   4'd4: v = 9'd56;
        4'd5: v = 9'd64;   4'd6: v = 9'd80;   4'd7: v = 9'd96;   4'd8: v = 9'd112;
        4'd9: v = 9'd128;  4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
        4'd13: v = 9'd256; 4'd14: v = 9'd320;
        default: v = '0;
      endcase
    end else begin
      case (idx)
        4'd1: v = 9'd8;    4'd2: v = 9'd16;   4'd3: v = 9'd24;   4'd4: v = 9'd32;
        4'd5: v = 9'd40;   4'd6: v = 9'd48;   4'd7: v = 9'd56;   4'd8: v = 9'd64;
        4'd9: v = 9'd80;   4'd10: v = 9'd96;  4'd11: v = 9'd112; 4'd12: v = 9'd128;
        4'd13: v = 9'd144; 4'd14: v = 9'd160;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] idx);
    logic [15:0] v;
    v = '0;
    case (ver)
      VER_MPEG1: begin
        case (idx)
          2'd0: v = 16'd44100; 2'd1: v = 16'd48000; 2'd2: v = 16'd32000;
          default: v = '0;
        endcase
      end
      VER_MPEG2: begin
        case (idx)
          2'd0: v = 16'd22050; 2'd1: v = 16'd24000; 2'd2: v = 16'd16000;
          default: v = '0;
        endcase
      end
      default: begin
        case (idx)
          2'd0: v = 16'd11025; 2'd1: v = 16'd12000; 2'd2: v = 16'd8000;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

>>> design/mahs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio header scanner divider
// Restoring divider, one quotient bit per cycle, shared by all three divides.
// ----------------------------------------------------------------------------
module mahs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [mahs_pkg::DIV_W-1:0]  dividend,
  input  logic [mahs_pkg::DSR_W-1:0]  divisor,
  output logic                        done,
  output logic [mahs_pkg::DIV_W-1:0]  quotient
);
  import mahs_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_W - 1);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_r)
    else $error("divider started while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider reports done while still busy");

endmodule

>>> design/mahs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio header scanner datapath
// Byte window, header decode, configuration, arithmetic and result register.
// ----------------------------------------------------------------------------
module mahs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mahs_pkg::mahs_in_t  in_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  mahs_pkg::mahs_cmd_t cmd,
  output mahs_pkg::mahs_sts_t sts,
  input  logic                out_stall,
  output mahs_pkg::mahs_out_t out_data
);
  import mahs_pkg::*;

  logic [31:0] base_r, len_r;
  logic [23:0] win_r;
  logic [31:0] idx_r;
  logic [1:0]  ver_r;
  logic [8:0]  kbps_r;
  logic [15:0] rate_r;
  logic        pad_r;
  logic [1:0]  mode_r;
  logic [31:0] hoff_r;
  logic [10:0] fs_r;
  logic [31:0] fc_r;
  logic [31:0] dur_r;
  logic [DIV_W-1:0] prod_r;
  mahs_out_t   out_r;
  logic        out_valid_r;

  logic [23:0] eff_win;
  logic [31:0] eff_idx, idx_inc;
  logic [7:0]  b0, b1, b2, b3;
  logic [1:0]  ver_c;
  logic        ver_ok;
  logic [8:0]  kbps_c;
  logic [15:0] rate_c;
  logic [10:0] spf_c;
  logic [5:0]  side_c;
  logic [31:0] remain;
  logic [26:0] fs_num;
  logic [DIV_W-1:0] prod_c;
  logic [DIV_W-1:0] div_a;
  logic [DSR_W-1:0] div_b;
  logic [DIV_W-1:0] div_q;
  logic        div_done;

  assign eff_win = in_data.start_req ? '0 : win_r;
  assign eff_idx = in_data.start_req ? '0 : idx_r;
  assign idx_inc = eff_idx + 32'd1;
  assign b0 = eff_win[23:16];
  assign b1 = eff_win[15:8];
  assign b2 = eff_win[7:0];
  assign b3 = in_data.data_byte;

  always_comb begin
    ver_c  = VER_MPEG1;
    ver_ok = 1'b1;
    unique case (b1[4:3])
      2'd3:    ver_c = VER_MPEG1;
      2'd2:    ver_c = VER_MPEG2;
      2'd0:    ver_c = VER_MPEG25;
      default: ver_ok = 1'b0;
    endcase
  end

  assign kbps_c = kbps_lookup(ver_c, b2[7:4]);
  assign rate_c = rate_lookup(ver_c, b2[3:2]);

  assign sts.hit = (idx_inc >= 32'd4) && (b0 == 8'hFF) && (b1[7:5] == 3'b111) && ver_ok
                   && (kbps_c != '0) && (rate_c != '0);
  assign sts.div_done  = div_done;
  assign sts.out_valid = out_valid_r;

  assign spf_c  = (ver_r == VER_MPEG1) ? 11'd1152 : 11'd576;
  assign side_c = (ver_r == VER_MPEG1) ? ((mode_r == MODE_MONO) ? 6'd17 : 6'd32)
                                       : ((mode_r == MODE_MONO) ? 6'd9 : 6'd17);
  assign fs_num = 27'((ver_r == VER_MPEG1) ? K_MPEG1 : K_MPEG2) * 27'(kbps_r);
  assign remain = (len_r > hoff_r) ? (len_r - hoff_r) : '0;
  assign prod_c = DIV_W'(spf_c) * DIV_W'(fc_r);

  always_comb begin
    div_a = DIV_W'(fs_num);
    div_b = rate_r;
    case (cmd.div_sel)
      SEL_FC: begin
        div_a = DIV_W'(remain);
        div_b = DSR_W'(fs_r);
      end
      SEL_DUR: begin
        div_a = prod_r;
        div_b = rate_r;
      end
      default: begin
        div_a = DIV_W'(fs_num);
        div_b = rate_r;
      end
    endcase
  end

  mahs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      len_r       <= '0;
      win_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) len_r <= cfg_data;
        else base_r <= cfg_data;
      end
      if (cmd.shift) begin
        win_r <= {eff_win[15:0], in_data.data_byte};
        idx_r <= idx_inc;
      end
      if (cmd.load_miss || cmd.load_hit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (cmd.shift && sts.hit) begin
      ver_r  <= ver_c;
      kbps_r <= kbps_c;
      rate_r <= rate_c;
      pad_r  <= b2[1];
      mode_r <= b3[7:6];
      hoff_r <= base_r + idx_inc - 32'd4;
    end
    if (cmd.cap_div) begin
      case (cmd.div_sel)
        SEL_FC:  fc_r  <= div_q[31:0];
        SEL_DUR: dur_r <= div_q[31:0];
        default: fs_r  <= div_q[10:0] + {10'd0, pad_r};
      endcase
    end
    if (cmd.cap_mul) prod_r <= prod_c;
    if (cmd.load_miss) begin
      out_r <= '0;
    end else if (cmd.load_hit) begin
      out_r.found            <= 1'b1;
      out_r.version          <= ver_r;
      out_r.bitrate_kbps     <= kbps_r;
      out_r.sample_rate_hz   <= rate_r;
      out_r.padding          <= pad_r;
      out_r.chan_mode        <= mode_r;
      out_r.frm_len          <= fs_r;
      out_r.frm_samples      <= spf_c;
      out_r.hdr_pos          <= hoff_r;
      out_r.frame_count      <= fc_r;
      out_r.duration_seconds <= dur_r;
      out_r.side_info_length <= side_c;
    end
  end

  assign out_data = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_miss || cmd.load_hit) |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");
  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_miss && cmd.load_hit))
    else $error("found and not-found results loaded together");

endmodule

>>> design/mahs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio header scanner controller
// Sequences the scan, the three divides, the product and the result load.
// ----------------------------------------------------------------------------
module mahs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_start,
  input  logic                in_last,
  output logic                in_stall,
  input  logic                out_stall,
  input  mahs_pkg::mahs_sts_t sts,
  output mahs_pkg::mahs_cmd_t cmd
);
  import mahs_pkg::*;

  localparam logic [3:0] S_SCAN = 4'd0;
  localparam logic [3:0] S_FS   = 4'd1;
  localparam logic [3:0] S_FSW  = 4'd2;
  localparam logic [3:0] S_FC   = 4'd3;
  localparam logic [3:0] S_FCW  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DU   = 4'd6;
  localparam logic [3:0] S_DUW  = 4'd7;
  localparam logic [3:0] S_HOLD = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       done_r, done_nxt;
  logic       out_block, acc, eff_done, active;

  assign out_block = sts.out_valid & out_stall;
  assign in_stall  = (state_r != S_SCAN) | out_block;
  assign acc       = in_valid & ~in_stall;
  assign eff_done  = in_start ? 1'b0 : done_r;
  assign active    = acc & ~eff_done;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    cmd       = '0;
    unique case (state_r)
      S_SCAN: begin
        cmd.shift = active;
        if (acc) done_nxt = eff_done;
        if (active && sts.hit) begin
          done_nxt  = 1'b1;
          state_nxt = S_FS;
        end else if (active && in_last) begin
          done_nxt      = 1'b1;
          cmd.load_miss = 1'b1;
        end
      end
      S_FS: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = SEL_FS;
        state_nxt   = S_FSW;
      end
      S_FSW: begin
        cmd.div_sel = SEL_FS;
        if (sts.div_done) begin
          cmd.cap_div = 1'b1;
          state_nxt   = S_FC;
        end
      end
      S_FC: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = SEL_FC;
        state_nxt   = S_FCW;
      end
      S_FCW: begin
        cmd.div_sel = SEL_FC;
        if (sts.div_done) begin
          cmd.cap_div = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.cap_mul = 1'b1;
        state_nxt   = S_DU;
      end
      S_DU: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = SEL_DUR;
        state_nxt   = S_DUW;
      end
      S_DUW: begin
        cmd.div_sel = SEL_DUR;
        if (sts.div_done) begin
          cmd.cap_div = 1'b1;
          state_nxt   = S_HOLD;
        end
      end
      S_HOLD: begin
        // The found item waits here until the result register is free.
        if (!out_block) begin
          cmd.load_hit = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      default: state_nxt = S_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SCAN;
      done_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  a_hit_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    (active && sts.hit) |=> (done_r && state_r == S_FS))
    else $error("header hit did not end the search");
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> !cmd.shift)
    else $error("byte taken while results are being computed");
  a_fs_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FSW && sts.div_done) |=> state_r == S_FC)
    else $error("frame size divide did not lead to frame count");

endmodule

>>> design/mpeg_audio_header_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio header scanner
// Finds the first valid MPEG audio frame header in a byte stream and reports
// its decoded fields with a CBR frame count and duration estimate.
// ----------------------------------------------------------------------------
// While searching, the block takes one byte per cycle. When a header is found
// the input stalls while the results are computed: three divides (frame size,
// frame count and duration) run one after another through a single restoring
// divider that produces one quotient bit per cycle over 43 bits, each with its
// start and capture, with the samples-times-frames product taken between the
// second and third divides, and then the result register is loaded with the
// found item. A stream end without a header gives its not-found item at once.
// The input also stalls while a finished item waits, stalled, in the result
// register.
module mpeg_audio_header_scanner_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mahs_pkg::mahs_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mahs_pkg::mahs_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);
  import mahs_pkg::*;

  mahs_cmd_t cmd;
  mahs_sts_t sts;

  assign cfg_ready = 1'b1;
  assign out_valid = sts.out_valid;

  mahs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_start  (in_data.start_req),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mahs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
